// ===== rtl/mspc_pkg.sv =====
`timescale 1ns / 1ps

package mspc_pkg;

  // capture timer width default
  localparam int CAPTURE_BITS_DEF = 16;

  // stream field widths
  localparam int OPER_W    = 2;
  localparam int CAPT_W    = 16;
  localparam int SPEED_W   = 32;
  localparam int DUTY_W    = 7;
  localparam int CMP_W     = 16;
  localparam int OUT_W     = 56;

  // arithmetic widths
  localparam int ERR_W     = 33;
  localparam int DIFF_W    = 34;
  localparam int SUM_W     = 40;
  localparam int MULB_W    = 41;
  localparam int PROD_W    = 58;
  localparam int ACC_W     = 60;
  localparam int DIV_W     = 32;
  localparam int DCNT_W    = 5;

  localparam logic [ACC_W-1:0]  DUTY_FULL = ACC_W'(100 * 65536);
  localparam logic [DUTY_W-1:0] DUTY_MAX  = DUTY_W'(100);
  localparam logic [DIV_W-1:0]  PERCENT   = DIV_W'(100);

  // divide by 100 as (x * ceil(2^30 / 100)) >> 30, exact for x below 2^23
  localparam int PCT_W    = 23;
  localparam int RECIP_W  = 24;
  localparam int RECIP_SH = 30;
  localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;

  // configuration register reset values
  localparam logic [21:0] TARGET_RST = 22'd0;
  localparam logic [15:0] GAIN_P_RST = 16'd256;
  localparam logic [15:0] GAIN_I_RST = 16'd26;
  localparam logic [15:0] GAIN_D_RST = 16'd256;
  localparam logic [31:0] NUMER_RST  = 32'd25423718;
  localparam logic [15:0] PERIOD_RST = 16'd2170;

  localparam int ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_TARGET = 3'd0,
    REG_GAIN_P = 3'd1,
    REG_GAIN_I = 3'd2,
    REG_GAIN_D = 3'd3,
    REG_NUMER  = 3'd4,
    REG_PERIOD = 3'd5
  } reg_idx_t;

  typedef enum logic [OPER_W-1:0] {
    EV_EDGE     = 2'd0,
    EV_OVF_SET  = 2'd1,
    EV_OVF_SVC  = 2'd2,
    EV_TICK     = 2'd3
  } event_t;

  // datapath micro-operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ROLL,
    OP_DELTA,
    OP_DIV,
    OP_SPEED,
    OP_OVF_SET,
    OP_OVF_SVC,
    OP_ERR,
    OP_SUM,
    OP_MUL_P,
    OP_MUL_I,
    OP_MUL_D,
    OP_ACC,
    OP_DUTY,
    OP_CMP_LOAD,
    OP_COMPARE
  } uop_t;

  typedef enum logic [1:0] {
    CND_NONE,
    CND_ALWAYS,
    CND_DELTA_ZERO,
    CND_DIV_MORE
  } cond_t;

  localparam int PC_W = 5;

  // program addresses
  localparam logic [PC_W-1:0] PC_FINISH  = 5'd0;
  localparam logic [PC_W-1:0] PC_EDGE    = 5'd1;
  localparam logic [PC_W-1:0] PC_E_DELTA = 5'd2;
  localparam logic [PC_W-1:0] PC_E_DIV   = 5'd3;
  localparam logic [PC_W-1:0] PC_E_SPEED = 5'd4;
  localparam logic [PC_W-1:0] PC_OVF_SET = 5'd5;
  localparam logic [PC_W-1:0] PC_OVF_SVC = 5'd6;
  localparam logic [PC_W-1:0] PC_TICK    = 5'd7;
  localparam logic [PC_W-1:0] PC_T_SUM   = 5'd8;
  localparam logic [PC_W-1:0] PC_T_MUL_P = 5'd9;
  localparam logic [PC_W-1:0] PC_T_MUL_I = 5'd10;
  localparam logic [PC_W-1:0] PC_T_MUL_D = 5'd11;
  localparam logic [PC_W-1:0] PC_T_ACC   = 5'd12;
  localparam logic [PC_W-1:0] PC_T_DUTY  = 5'd13;
  localparam logic [PC_W-1:0] PC_T_CLOAD = 5'd14;
  localparam logic [PC_W-1:0] PC_T_CMP   = 5'd15;

  typedef struct packed {
    uop_t            op;
    cond_t           cond;
    logic [PC_W-1:0] target;
    logic            done;
  } ctrl_word_t;

  // microprogram rom
  function automatic ctrl_word_t mc_rom(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    w = '{op: OP_NOP, cond: CND_NONE, target: PC_FINISH, done: 1'b1};
    unique case (pc)
      PC_FINISH:  w = '{op: OP_NOP,      cond: CND_NONE,       target: PC_FINISH, done: 1'b1};
      PC_EDGE:    w = '{op: OP_ROLL,     cond: CND_NONE,       target: PC_FINISH, done: 1'b0};
      PC_E_DELTA: w = '{op: OP_DELTA,    cond: CND_DELTA_ZERO, target: PC_FINISH, done: 1'b0};
      PC_E_DIV:   w = '{op: OP_DIV,      cond: CND_DIV_MORE,   target: PC_E_DIV,  done: 1'b0};
      PC_E_SPEED: w = '{op: OP_SPEED,    cond: CND_ALWAYS,     target: PC_FINISH, done: 1'b0};
      PC_OVF_SET: w = '{op: OP_OVF_SET,  cond: CND_ALWAYS,     target: PC_FINISH, done: 1'b0};
      PC_OVF_SVC: w = '{op: OP_OVF_SVC,  cond: CND_ALWAYS,     target: PC_FINISH, done: 1'b0};
      PC_TICK:    w = '{op: OP_ERR,      cond: CND_NONE,       target: PC_FINISH, done: 1'b0};
      PC_T_SUM:   w = '{op: OP_SUM,      cond: CND_NONE,       target: PC_FINISH, done: 1'b0};
      PC_T_MUL_P: w = '{op: OP_MUL_P,    cond: CND_NONE,       target: PC_FINISH, done: 1'b0};
      PC_T_MUL_I: w = '{op: OP_MUL_I,    cond: CND_NONE,       target: PC_FINISH, done: 1'b0};
      PC_T_MUL_D: w = '{op: OP_MUL_D,    cond: CND_NONE,       target: PC_FINISH, done: 1'b0};
      PC_T_ACC:   w = '{op: OP_ACC,      cond: CND_NONE,       target: PC_FINISH, done: 1'b0};
      PC_T_DUTY:  w = '{op: OP_DUTY,     cond: CND_NONE,       target: PC_FINISH, done: 1'b0};
      PC_T_CLOAD: w = '{op: OP_CMP_LOAD, cond: CND_NONE,       target: PC_FINISH, done: 1'b0};
      PC_T_CMP:   w = '{op: OP_COMPARE,  cond: CND_ALWAYS,     target: PC_FINISH, done: 1'b0};
      default:    w = '{op: OP_NOP,      cond: CND_NONE,       target: PC_FINISH, done: 1'b1};
    endcase
    return w;
  endfunction

  // program entry per event kind
  function automatic logic [PC_W-1:0] mc_entry(input event_t ev);
    logic [PC_W-1:0] pc;
    pc = PC_FINISH;
    unique case (ev)
      EV_EDGE:    pc = PC_EDGE;
      EV_OVF_SET: pc = PC_OVF_SET;
      EV_OVF_SVC: pc = PC_OVF_SVC;
      EV_TICK:    pc = PC_TICK;
      default:    pc = PC_FINISH;
    endcase
    return pc;
  endfunction

endpackage

// ===== rtl/motor_speed_pid_controller.sv =====
`timescale 1ns / 1ps

// channel   | dir | handshake                | payload
// ----------+-----+--------------------------+-------------------------------------------
// s_ (event)| in  | s_tvalid / s_tready      | s_tuser = operation, s_tdata = capture_time
// m_ (state)| out | m_tvalid / m_tready      | m_tdata = speed, duty, compare, clamped
// apb cfg   | in  | psel & penable & pwrite  | paddr = 4 * register index, pwdata
//
// sequencing: a microprogram runs each event; s_tready drops for its length. the
//   1-bit-per-cycle divider sets the long path: the encoder edge program is the
//   longest and skips the divide on a zero time difference; the control tick
//   and the overflow event programs are shorter.
// reset: rst is synchronous, active high; state clears, registers take defaults;
//   s_tready stays low while rst is high.
// stalls: the finish step holds while a result still waits on m_; a new event
//   is taken while the previous result waits.

module motor_speed_pid_controller #(
  parameter int CAPTURE_BITS = mspc_pkg::CAPTURE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // event stream
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [mspc_pkg::CAPT_W-1:0]  s_tdata,   // [15:0] capture_time
  input  logic [mspc_pkg::OPER_W-1:0]  s_tuser,   // [1:0] operation
  // result stream
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [mspc_pkg::OUT_W-1:0]   m_tdata,   // [31:0] speed, [38:32] duty_percent,
                                                  // [54:39] compare_value, [55] clamped
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mspc_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import mspc_pkg::*;

  // capture extension constants
  localparam logic [31:0] CAP_MASK = 32'((64'd1 << CAPTURE_BITS) - 64'd1);
  localparam logic [31:0] CAP_HALF = 32'(64'd1 << (CAPTURE_BITS - 1));

  // configuration registers
  logic [21:0] target_speed;
  logic [15:0] gain_p;
  logic [15:0] gain_i;
  logic [15:0] gain_d;
  logic [31:0] speed_numerator;
  logic [15:0] pwm_period;

  // architectural state
  logic [15:0]              rollover_count;
  logic                     overflow_pending;
  logic [31:0]              previous_time;
  logic [SPEED_W-1:0]       measured_speed;
  logic signed [SUM_W-1:0]  error_sum;
  logic signed [SUM_W-1:0]  old_sum;
  logic signed [ERR_W-1:0]  previous_error;
  logic [DUTY_W-1:0]        duty_level;
  logic [CMP_W-1:0]         compare_level;
  logic                     clamp_flag;

  // working registers of the datapath
  logic [31:0]              cap_r;
  logic signed [ERR_W-1:0]  err_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic [DIV_W-1:0]         div_rem;
  logic [DIV_W-1:0]         div_quo;
  logic [DIV_W-1:0]         div_den;
  logic [DCNT_W-1:0]        div_cnt;

  // sequencer
  logic            busy;
  logic [PC_W-1:0] pc;
  ctrl_word_t      cw;
  logic            in_xact;
  logic            out_free;
  logic            finish;
  logic            exec;
  logic            jump;

  logic                     cfg_wr;
  reg_idx_t                 cfg_idx;

  logic [31:0]              now_c;
  logic [31:0]              delta_c;
  logic signed [SUM_W:0]    sum_wide;
  logic signed [SUM_W-1:0]  sum_sat;
  logic [DIV_W:0]           rem_sh;
  logic                     rem_ge;
  logic [15:0]              gain_sel;
  logic signed [MULB_W-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_out;
  logic [PCT_W+RECIP_W-1:0] pct_prod;

  // ---------------------------------------------------------------------------
  // apb configuration port
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      target_speed    <= TARGET_RST;
      gain_p          <= GAIN_P_RST;
      gain_i          <= GAIN_I_RST;
      gain_d          <= GAIN_D_RST;
      speed_numerator <= NUMER_RST;
      pwm_period      <= PERIOD_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TARGET: target_speed    <= pwdata[21:0];
        REG_GAIN_P: gain_p          <= pwdata[15:0];
        REG_GAIN_I: gain_i          <= pwdata[15:0];
        REG_GAIN_D: gain_d          <= pwdata[15:0];
        REG_NUMER:  speed_numerator <= pwdata;
        REG_PERIOD: pwm_period      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_TARGET: prdata = {10'd0, target_speed};
      REG_GAIN_P: prdata = {16'd0, gain_p};
      REG_GAIN_I: prdata = {16'd0, gain_i};
      REG_GAIN_D: prdata = {16'd0, gain_d};
      REG_NUMER:  prdata = speed_numerator;
      REG_PERIOD: prdata = {16'd0, pwm_period};
      default:    prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // microsequencer: step counter, control word from rom, conditional jumps
  // ---------------------------------------------------------------------------
  assign s_tready = !busy && !rst;
  assign in_xact  = s_tvalid && s_tready;
  assign cw       = mc_rom(pc);
  assign out_free = !m_tvalid || m_tready;
  // finish step publishes the state snapshot once the output slot is free
  assign finish   = busy && cw.done && out_free;
  assign exec     = busy && !cw.done;

  always_comb begin
    case (cw.cond)
      CND_NONE:       jump = 1'b0;
      CND_ALWAYS:     jump = 1'b1;
      CND_DELTA_ZERO: jump = (delta_c == 32'd0);
      CND_DIV_MORE:   jump = (div_cnt != '1);
      default:        jump = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= PC_FINISH;
    end else if (in_xact) begin
      busy <= 1'b1;
      pc   <= mc_entry(event_t'(s_tuser));
    end else if (finish) begin
      busy <= 1'b0;
    end else if (exec) begin
      pc   <= jump ? cw.target : pc + PC_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // combinational datapath pieces
  // ---------------------------------------------------------------------------
  // 32-bit time from rollover count and capture
  assign now_c   = 32'(({48'd0, rollover_count} << CAPTURE_BITS) | {32'd0, cap_r});
  assign delta_c = now_c - previous_time;

  // saturating integral update
  assign sum_wide = {error_sum[SUM_W-1], error_sum}
                  + (SUM_W+1)'(err_r);
  always_comb begin
    case (sum_wide[SUM_W:SUM_W-1])
      2'b01:   sum_sat = {1'b0, {(SUM_W-1){1'b1}}};
      2'b10:   sum_sat = {1'b1, {(SUM_W-1){1'b0}}};
      default: sum_sat = sum_wide[SUM_W-1:0];
    endcase
  end

  // restoring divider, one quotient bit per step
  assign rem_sh = {div_rem, div_quo[DIV_W-1]};
  assign rem_ge = rem_sh >= {1'b0, div_den};

  // duty times period scaled by the reciprocal of 100
  assign pct_prod = (PCT_W+RECIP_W)'(div_quo[PCT_W-1:0])
                  * (PCT_W+RECIP_W)'(RECIP_100);

  // one shared gain multiplier, operands picked by the micro-op
  always_comb begin
    case (cw.op)
      OP_MUL_I: begin
        gain_sel = gain_i;
        mul_b    = MULB_W'(error_sum);
      end
      OP_MUL_D: begin
        gain_sel = gain_d;
        mul_b    = MULB_W'(diff_r);
      end
      default: begin
        gain_sel = gain_p;
        mul_b    = MULB_W'(err_r);
      end
    endcase
  end
  assign mul_out = PROD_W'($signed({1'b0, gain_sel}) * mul_b);

  // architectural state, reset to zero
  always_ff @(posedge clk) begin
    if (rst) begin
      rollover_count   <= '0;
      overflow_pending <= 1'b0;
      previous_time    <= '0;
      measured_speed   <= '0;
      error_sum        <= '0;
      previous_error   <= '0;
      duty_level       <= '0;
      compare_level    <= '0;
      clamp_flag       <= 1'b0;
    end else if (exec) begin
      case (cw.op)
        OP_ROLL: begin
          // race fix: capture in the lower half with an overflow pending
          if (cap_r < CAP_HALF && overflow_pending) begin
            rollover_count   <= rollover_count + 16'd1;
            overflow_pending <= 1'b0;
          end
        end
        OP_DELTA:   previous_time <= now_c;
        OP_SPEED:   measured_speed <= div_quo;
        OP_OVF_SET: overflow_pending <= 1'b1;
        OP_OVF_SVC: begin
          if (overflow_pending) begin
            rollover_count   <= rollover_count + 16'd1;
            overflow_pending <= 1'b0;
          end
        end
        OP_SUM: begin
          error_sum      <= sum_sat;
          previous_error <= err_r;
        end
        OP_DUTY: begin
          if (acc > $signed(DUTY_FULL)) begin
            duty_level <= DUTY_MAX;
            clamp_flag <= 1'b1;
            error_sum  <= old_sum;
          end else if (acc < 0) begin
            duty_level <= '0;
            clamp_flag <= 1'b1;
            error_sum  <= old_sum;
          end else begin
            duty_level <= acc[16 +: DUTY_W];
            clamp_flag <= 1'b0;
          end
        end
        OP_COMPARE: compare_level <= pct_prod[RECIP_SH +: CMP_W];
        default: ;
      endcase
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_xact) begin
      cap_r <= 32'(s_tdata) & CAP_MASK;
    end
    if (exec) begin
      case (cw.op)
        OP_DELTA: begin
          div_rem <= '0;
          div_quo <= speed_numerator;
          div_den <= delta_c;
          div_cnt <= '0;
        end
        OP_DIV: begin
          div_rem <= rem_ge ? DIV_W'(rem_sh - {1'b0, div_den}) : rem_sh[DIV_W-1:0];
          div_quo <= {div_quo[DIV_W-2:0], rem_ge};
          div_cnt <= div_cnt + DCNT_W'(1);
        end
        OP_ERR: err_r <= ERR_W'($signed({11'd0, target_speed})
                                - $signed({1'b0, measured_speed}));
        OP_SUM: begin
          old_sum <= error_sum;
          diff_r  <= DIFF_W'(err_r) - DIFF_W'(previous_error);
        end
        OP_MUL_P: begin
          prod <= mul_out;
          acc  <= '0;
        end
        OP_MUL_I, OP_MUL_D: begin
          prod <= mul_out;
          acc  <= acc + ACC_W'(prod);
        end
        OP_ACC: acc <= acc + ACC_W'(prod);
        OP_CMP_LOAD: begin
          // duty times period, divided by 100 on the next step
          div_quo <= DIV_W'(duty_level) * DIV_W'(pwm_period);
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      m_tdata <= {clamp_flag, compare_level, duty_level, measured_speed};
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // an accepted event sets the sequencer busy and drops s_tready
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("event accepted but sequencer not busy");

  // results only come out of a running microprogram
  a_result_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(busy))
    else $error("result appeared without a running program");

  // a saturated duty is always one of the two limits
  a_clamp_limits: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[55]) |-> (m_tdata[38:32] == 7'd0 || m_tdata[38:32] == 7'd100))
    else $error("clamped duty not at a limit");

  // duty never exceeds full scale
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[38:32] <= 7'd100))
    else $error("duty above 100 percent");

endmodule
